// ===== rtl/core/ptp_pkg.sv =====
package ptp_pkg;

	localparam int DATA_W  = 32;
	localparam int SPEED_W = 24;
	localparam int CFG_W   = 24;
	localparam int INDEX_W = 8;
	localparam int RAD_W   = 58;
	localparam int REM_W   = 34;

	localparam logic [INDEX_W-1:0] REG_MAX_ACCEL = 8'd0;
	localparam logic [INDEX_W-1:0] REG_MAX_SPEED = 8'd1;

	localparam logic [CFG_W-1:0] MAX_ACCEL_RST = 24'd65536;
	localparam logic [CFG_W-1:0] MAX_SPEED_RST = 24'd65536;

	localparam logic [DATA_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [DATA_W-1:0] station;
		logic [DATA_W-1:0] seg_start;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  time_stamp;
		logic [SPEED_W-1:0] speed;
		logic               last_point;
	} out_item_t;

	typedef enum logic {
		MODE_SQRT = 1'b0,
		MODE_DIV  = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ===== rtl/core/ptp_ram.sv =====
module ptp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/ptp_iter.sv =====
module ptp_iter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ptp_pkg::unit_cmd_t                    cmd,
	input  logic [ptp_pkg::RAD_W-1:0]             rad,
	input  logic [ptp_pkg::DATA_W+FRAC_BITS-1:0]  num,
	input  logic [ptp_pkg::SPEED_W-1:0]           den,
	output ptp_pkg::unit_sts_t                    sts,
	output logic [((ptp_pkg::DATA_W+FRAC_BITS > ptp_pkg::RAD_W) ?
		(ptp_pkg::DATA_W+FRAC_BITS) : ptp_pkg::RAD_W)-1:0] res
);

	localparam int NUM_W = ptp_pkg::DATA_W + FRAC_BITS;
	localparam int SH_W  = (NUM_W > ptp_pkg::RAD_W) ? NUM_W : ptp_pkg::RAD_W;
	localparam int CNT_W = $clog2(SH_W + 1);
	localparam int REM_W = ptp_pkg::REM_W;

	logic [SH_W-1:0]    acc_q;
	logic [REM_W-1:0]   rem_q;
	logic [SH_W-1:0]    res_q;
	logic [CNT_W-1:0]   cnt_q;
	ptp_pkg::unit_mode_t mode_q;
	logic               busy_q;
	logic               done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;
	logic             fits;

	always_comb begin
		if (mode_q == ptp_pkg::MODE_SQRT) begin
			rem_sh = {rem_q[REM_W-3:0], acc_q[SH_W-1 -: 2]};
			trial  = {res_q[REM_W-3:0], 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], acc_q[SH_W-1]};
			trial  = REM_W'(den);
		end
		diff = {1'b0, rem_sh} - {1'b0, trial};
		fits = !diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			rem_q  <= '0;
			res_q  <= '0;
			if (cmd.mode == ptp_pkg::MODE_SQRT) begin
				acc_q <= SH_W'(rad) << (SH_W - ptp_pkg::RAD_W);
				cnt_q <= CNT_W'(ptp_pkg::RAD_W / 2);
			end else begin
				acc_q <= SH_W'(num) << (SH_W - NUM_W);
				cnt_q <= CNT_W'(NUM_W);
			end
		end else if (busy_q) begin
			rem_q <= fits ? diff[REM_W-1:0] : rem_sh;
			res_q <= {res_q[SH_W-2:0], fits};
			cnt_q <= cnt_q - CNT_W'(1);
			if (mode_q == ptp_pkg::MODE_SQRT) begin
				acc_q <= acc_q << 2;
			end else begin
				acc_q <= acc_q << 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

// ===== rtl/core/path_time_profile.sv =====
// Loading accepts points back to back; the point marked last starts planning.
// Planning runs a forward and a backward pass over the points, each step
// set by the 29-step square root of the shared iterative unit, then one
// result per point, from its divider where the point's speed is nonzero.
// No point is taken until the last result of a segment is transferred.
// Reset clears the sequencer and the counters and reloads the config registers, not the datapath or the stores.
module path_time_profile #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ptp_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ptp_pkg::out_item_t            out_data,
	input  logic                          wr_en,
	input  logic [ptp_pkg::INDEX_W-1:0]   wr_index,
	input  logic [ptp_pkg::CFG_W-1:0]     wr_data
);

	localparam int DW    = ptp_pkg::DATA_W;
	localparam int SW    = ptp_pkg::SPEED_W;
	localparam int RW    = ptp_pkg::RAD_W;
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int NUM_W = DW + FRAC_BITS;
	localparam int SH_W  = (NUM_W > RW) ? NUM_W : RW;
	localparam int MW    = SW + DW;

	typedef enum logic [14:0] {
		S_LOAD   = 15'b000000000000001,
		S_F_INIT = 15'b000000000000010,
		S_F_PREV = 15'b000000000000100,
		S_GET    = 15'b000000000001000,
		S_MUL1   = 15'b000000000010000,
		S_MUL2   = 15'b000000000100000,
		S_RAD    = 15'b000000001000000,
		S_SQRT   = 15'b000000010000000,
		S_B_INIT = 15'b000000100000000,
		S_O_INIT = 15'b000001000000000,
		S_O_GET  = 15'b000010000000000,
		S_O_CHK  = 15'b000100000000000,
		S_O_DIV  = 15'b001000000000000,
		S_O_EMIT = 15'b010000000000000,
		S_O_WAIT = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [SW-1:0]     max_accel_q;
	logic [SW-1:0]     max_speed_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     idx_q;
	logic              back_q;
	logic [DW-1:0]     start_hold_q;
	logic [DW-1:0]     st_prev_q;
	logic [DW-1:0]     cur_q;
	logic [SW-1:0]     spc_q;
	logic [SW-1:0]     v_q;
	logic              neg_q;
	logic              up_q;
	logic [2*SW-1:0]   vsq_q;
	logic [MW-1:0]     prod_q;
	logic [DW-1:0]     t_q;
	logic              out_valid_q;
	ptp_pkg::out_item_t out_q;

	logic          st_we;
	logic [AW-1:0] st_raddr;
	logic [DW-1:0] st_rdata;
	logic          sp_we;
	logic [AW-1:0] sp_waddr;
	logic [SW-1:0] sp_wdata;
	logic [AW-1:0] sp_raddr;
	logic [SW-1:0] sp_rdata;

	logic [SW-1:0] mul_a;
	logic [DW-1:0] mul_b;
	logic [MW-1:0] mul_p;
	logic [DW-1:0] ds_mag;
	logic [RW-1:0] rad;
	logic [RW-1:0] two_prod;
	logic [RW-1:0] vsq_ext;
	logic [DW-1:0] od_mag;
	logic [SW-1:0] v_new;
	logic [NUM_W:0] t_sum;
	logic [NUM_W-1:0] quo;

	ptp_pkg::unit_cmd_t unit_cmd;
	ptp_pkg::unit_sts_t unit_sts;
	logic [SH_W-1:0]    unit_res;

	logic in_fire;
	logic room;
	logic [CW-1:0] n_last;

	assign in_fire = in_valid && in_ready;
	assign room    = cnt_q < CW'(MAX_POINTS);
	assign n_last  = n_q - CW'(1);

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st_we = in_fire && room;

	always_comb begin
		unique case (state_q)
			S_GET:   st_raddr = back_q ? AW'(idx_q - CW'(1)) : AW'(idx_q);
			S_O_GET: st_raddr = AW'(idx_q);
			default: st_raddr = '0;
		endcase
		sp_raddr = (state_q == S_GET) ? AW'(idx_q - CW'(1)) : AW'(idx_q);
	end

	ptp_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_station_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (AW'(cnt_q)),
		.wdata (in_data.station),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ptp_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_speed_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (sp_raddr),
		.rdata (sp_rdata)
	);

	always_comb begin
		if (state_q == S_MUL1) begin
			mul_a = v_q;
			mul_b = DW'(v_q);
		end else begin
			mul_a = max_accel_q;
			mul_b = ds_mag;
		end
		mul_p = MW'(mul_a) * MW'(mul_b);
	end

	always_comb begin
		if (back_q) begin
			ds_mag = (st_prev_q >= cur_q) ? st_prev_q - cur_q : cur_q - st_prev_q;
		end else begin
			ds_mag = (cur_q >= st_prev_q) ? cur_q - st_prev_q : st_prev_q - cur_q;
		end
		two_prod = {1'b0, prod_q, 1'b0};
		vsq_ext  = RW'(vsq_q);
		if (!neg_q) begin
			rad = vsq_ext + two_prod;
		end else if (two_prod >= vsq_ext) begin
			rad = '0;
		end else begin
			rad = vsq_ext - two_prod;
		end
		v_new = (unit_res > SH_W'(max_speed_q)) ? max_speed_q : unit_res[SW-1:0];
		od_mag = (st_rdata >= st_prev_q) ? st_rdata - st_prev_q : st_prev_q - st_rdata;
		quo   = unit_res[NUM_W-1:0];
		t_sum = (NUM_W+1)'(t_q) + (NUM_W+1)'(quo);
	end

	always_comb begin
		unit_cmd.start = 1'b0;
		unit_cmd.mode  = ptp_pkg::MODE_SQRT;
		if (state_q == S_RAD) begin
			unit_cmd.start = 1'b1;
		end else if (state_q == S_O_CHK && idx_q != '0 && sp_rdata != '0) begin
			unit_cmd.start = 1'b1;
			unit_cmd.mode  = ptp_pkg::MODE_DIV;
		end
	end

	ptp_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (unit_cmd),
		.rad    (rad),
		.num    ({od_mag, FRAC_BITS'(0)}),
		.den    (sp_rdata),
		.sts    (unit_sts),
		.res    (unit_res)
	);

	always_comb begin
		sp_we    = 1'b0;
		sp_waddr = '0;
		sp_wdata = '0;
		unique case (state_q)
			S_F_INIT: begin
				sp_we = 1'b1;
			end
			S_B_INIT: begin
				sp_we    = 1'b1;
				sp_waddr = AW'(n_last);
			end
			S_SQRT: begin
				if (unit_sts.done) begin
					if (!back_q) begin
						sp_we    = 1'b1;
						sp_waddr = AW'(idx_q);
						sp_wdata = v_new;
					end else if (v_new < spc_q) begin
						sp_we    = 1'b1;
						sp_waddr = AW'(idx_q - CW'(1));
						sp_wdata = v_new;
					end
				end
			end
			default: begin
				sp_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q <= ptp_pkg::MAX_ACCEL_RST;
			max_speed_q <= ptp_pkg::MAX_SPEED_RST;
		end else if (wr_en) begin
			if (wr_index == ptp_pkg::REG_MAX_ACCEL) begin
				max_accel_q <= wr_data;
			end else if (wr_index == ptp_pkg::REG_MAX_SPEED) begin
				max_speed_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			n_q          <= '0;
			idx_q        <= '0;
			back_q       <= 1'b0;
			start_hold_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
							if (cnt_q == '0) begin
								start_hold_q <= in_data.seg_start;
							end
						end
						if (in_data.last) begin
							n_q     <= room ? cnt_q + CW'(1) : cnt_q;
							state_q <= S_F_INIT;
						end
					end
				end
				S_F_INIT: state_q <= S_F_PREV;
				S_F_PREV: begin
					idx_q   <= CW'(1);
					back_q  <= 1'b0;
					state_q <= (n_q == CW'(1)) ? S_B_INIT : S_GET;
				end
				S_GET:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_RAD;
				S_RAD:  state_q <= S_SQRT;
				S_SQRT: begin
					if (unit_sts.done) begin
						if (!back_q) begin
							if (idx_q == n_last) begin
								state_q <= S_B_INIT;
							end else begin
								idx_q   <= idx_q + CW'(1);
								state_q <= S_GET;
							end
						end else if (idx_q == CW'(1)) begin
							state_q <= S_O_INIT;
						end else begin
							idx_q   <= idx_q - CW'(1);
							state_q <= S_GET;
						end
					end
				end
				S_B_INIT: begin
					idx_q   <= n_last;
					back_q  <= 1'b1;
					state_q <= (n_q == CW'(1)) ? S_O_INIT : S_GET;
				end
				S_O_INIT: begin
					idx_q   <= '0;
					state_q <= S_O_GET;
				end
				S_O_GET: state_q <= S_O_CHK;
				S_O_CHK: state_q <= unit_cmd.start ? S_O_DIV : S_O_EMIT;
				S_O_DIV: begin
					if (unit_sts.done) begin
						state_q <= S_O_EMIT;
					end
				end
				S_O_EMIT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (idx_q == n_last) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_O_GET;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_F_PREV: begin
				st_prev_q <= st_rdata;
				v_q       <= '0;
			end
			S_B_INIT: v_q <= '0;
			S_MUL1: begin
				cur_q <= st_rdata;
				spc_q <= sp_rdata;
				vsq_q <= mul_p[2*SW-1:0];
			end
			S_MUL2: begin
				prod_q <= mul_p;
				neg_q  <= back_q ? (st_prev_q < cur_q) : (cur_q < st_prev_q);
			end
			S_SQRT: begin
				if (unit_sts.done) begin
					v_q       <= v_new;
					st_prev_q <= cur_q;
				end
			end
			S_O_INIT: t_q <= start_hold_q;
			S_O_CHK: begin
				cur_q <= st_rdata;
				spc_q <= sp_rdata;
				up_q  <= st_rdata >= st_prev_q;
			end
			S_O_DIV: begin
				if (unit_sts.done) begin
					if (up_q) begin
						t_q <= (t_sum > (NUM_W+1)'(ptp_pkg::TIME_MAX)) ?
							ptp_pkg::TIME_MAX : t_sum[DW-1:0];
					end else if (quo >= NUM_W'(t_q)) begin
						t_q <= '0;
					end else begin
						t_q <= t_q - quo[DW-1:0];
					end
				end
			end
			S_O_EMIT: begin
				out_q.time_stamp <= t_q;
				out_q.speed      <= spc_q;
				out_q.last_point <= idx_q == n_last;
			end
			S_O_WAIT: begin
				if (out_ready) begin
					st_prev_q <= cur_q;
				end
			end
			default: begin
				v_q <= v_q;
			end
		endcase
	end

endmodule
